// ===== sv/gsc_pkg.sv =====
// Shared types and codes of the slider gesture classifier.
`default_nettype none

package gsc_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_SPEED_SCALE   = 8'd0;
  localparam logic [7:0] CFG_FLING_SPEED   = 8'd1;
  localparam logic [7:0] CFG_SLOW_NEEDED   = 8'd2;
  localparam logic [7:0] CFG_MOVE_MIN_DIST = 8'd3;

  // Configuration reset values
  localparam logic [15:0] RST_SPEED_SCALE   = 16'd1000;
  localparam logic [15:0] RST_FLING_SPEED   = 16'd100;
  localparam logic [7:0]  RST_SLOW_NEEDED   = 8'd3;
  localparam logic [15:0] RST_MOVE_MIN_DIST = 16'd2;

  typedef enum logic [1:0] {
    EV_DOWN  = 2'd0,
    EV_MOVE  = 2'd1,
    EV_FLING = 2'd2,
    EV_UP    = 2'd3
  } gsc_kind_t;

  typedef struct packed {
    gsc_kind_t   kind;
    logic        backward;
    logic [15:0] distance;
    logic        last_of_run;
  } gsc_event_t;

  // Status word of the speed comparison unit
  typedef struct packed {
    logic done;       // one-cycle pulse, flags below valid from then on
    logic fast_last;  // distance to anchor counts as fast
    logic fast_near;  // distance to previous sample counts as fast
  } gsc_fast_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CALC  = 2'd1,
    ST_WRITE = 2'd2
  } gsc_state_t;

endpackage

`default_nettype wire

// ===== sv/gsc_speed_cmp.sv =====
// Bit-serial speed comparison: scale*dist >= fling*elapsed for two distances.
`default_nettype none

module gsc_speed_cmp
  import gsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] scale,
  input  wire logic [15:0] fling,
  input  wire logic [15:0] dist_last,
  input  wire logic [15:0] dist_near,
  input  wire logic [31:0] elapsed,
  output gsc_fast_t        fast
);

  logic [15:0] scale_sr_r, scale_sr_nxt;
  logic [15:0] fling_sr_r, fling_sr_nxt;
  logic        fling_zero_r;
  logic [15:0] dl_r, dn_r;
  logic [31:0] el_r;
  logic [31:0] acc_l_r, acc_l_nxt;
  logic [31:0] acc_n_r, acc_n_nxt;
  logic [47:0] acc_e_r, acc_e_nxt;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        cmp_r;
  gsc_fast_t   fast_r;
  logic        el_zero;

  // One multiplier bit per cycle, most significant first
  always_comb begin
    acc_l_nxt    = {acc_l_r[30:0], 1'b0} + (scale_sr_r[15] ? {16'd0, dl_r} : 32'd0);
    acc_n_nxt    = {acc_n_r[30:0], 1'b0} + (scale_sr_r[15] ? {16'd0, dn_r} : 32'd0);
    acc_e_nxt    = {acc_e_r[46:0], 1'b0} + (fling_sr_r[15] ? {16'd0, el_r} : 48'd0);
    scale_sr_nxt = {scale_sr_r[14:0], 1'b0};
    fling_sr_nxt = {fling_sr_r[14:0], 1'b0};
  end

  assign el_zero = (el_r == 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cmp_r  <= 1'b0;
      fast_r <= '0;
      cnt_r  <= '0;
    end else begin
      // pulse done in the cycle after the compare
      fast_r.done <= cmp_r && !start && !busy_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          cmp_r  <= 1'b1;
        end
      end else if (cmp_r) begin
        cmp_r            <= 1'b0;
        // zero elapsed time means zero speed
        fast_r.fast_last <= el_zero ? fling_zero_r : ({16'd0, acc_l_r} >= acc_e_r);
        fast_r.fast_near <= el_zero ? fling_zero_r : ({16'd0, acc_n_r} >= acc_e_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scale_sr_r   <= scale;
      fling_sr_r   <= fling;
      fling_zero_r <= (fling == 16'd0);
      dl_r         <= dist_last;
      dn_r         <= dist_near;
      el_r         <= elapsed;
      acc_l_r      <= '0;
      acc_n_r      <= '0;
      acc_e_r      <= '0;
    end else if (busy_r) begin
      scale_sr_r <= scale_sr_nxt;
      fling_sr_r <= fling_sr_nxt;
      acc_l_r    <= acc_l_nxt;
      acc_n_r    <= acc_n_nxt;
      acc_e_r    <= acc_e_nxt;
    end
  end

  assign fast = fast_r;

endmodule

`default_nettype wire

// ===== sv/slider_gesture_classifier.sv =====
// Top level of the slider gesture classifier.
//
// Turns slider samples (press flag, signed position, 32-bit tick) into gesture
// events: down, move, fling and up, each with a direction flag, a distance from
// the anchor and a flag marking the last event of its sample. A sample yields
// zero, one or two events. Every sample runs through the speed test before
// its events are loaded into the output stage: the speed test multiplies
// scale by distance and fling threshold by elapsed ticks one multiplier bit per
// cycle in a serial unit, then compares, hands the result over and commits.
// The input opens again in the cycle after the commit, so the block takes no
// new sample before the last one has committed. The commit waits until the
// output stage is empty, so a stalled consumer delays the next sample; a new
// sample is accepted while earlier events still wait to be taken. Elapsed
// ticks wrap modulo 2^32 and a zero elapsed time counts as zero speed.
// Configuration writes are accepted in any cycle but are meant to be made only
// while the block is idle; unknown register indexes are ignored.
`default_nettype none

module slider_gesture_classifier
  import gsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // sample input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_pressed,
  input  wire logic [15:0] in_position,
  input  wire logic [31:0] in_now_tick,
  // event output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic             out_backward,
  output logic [15:0]      out_distance,
  output logic             out_last_of_run,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] speed_scale_r, fling_speed_r, move_min_r;
  logic [7:0]  slow_needed_r;

  // Gesture state
  logic        is_pressed_r, is_pressed_nxt;
  logic [15:0] anchor_r, anchor_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [8:0]  slow_cnt_r, slow_cnt_nxt;
  logic [31:0] start_tick_r, start_tick_nxt;

  // Sample held while the speed test runs
  logic        press_r;
  logic [15:0] pos_r;
  logic [31:0] now_r;
  logic [15:0] dist_last_r, dist_near_r;
  logic        back_r;

  // Output stage and the word queued behind it
  gsc_event_t out_r, out_nxt, pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt, pend_valid_r, pend_valid_nxt;

  gsc_state_t state_r, state_nxt;
  logic       accept, commit;
  gsc_fast_t  fast;

  logic [16:0] diff_last, diff_near;
  logic [15:0] dist_last, dist_near;
  logic [31:0] elapsed;

  gsc_event_t ev0, ev1;
  logic [1:0] n_ev;
  logic       slow_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r <= RST_SPEED_SCALE;
      fling_speed_r <= RST_FLING_SPEED;
      slow_needed_r <= RST_SLOW_NEEDED;
      move_min_r    <= RST_MOVE_MIN_DIST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPEED_SCALE:   speed_scale_r <= cfg_data;
        CFG_FLING_SPEED:   fling_speed_r <= cfg_data;
        CFG_SLOW_NEEDED:   slow_needed_r <= cfg_data[7:0];
        CFG_MOVE_MIN_DIST: move_min_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Distances measured at acceptance; a 17-bit difference never overflows
  assign diff_last = {in_position[15], in_position} - {anchor_r[15], anchor_r};
  assign diff_near = {in_position[15], in_position} - {prev_r[15], prev_r};
  assign dist_last = diff_last[16] ? 16'(-diff_last) : diff_last[15:0];
  assign dist_near = diff_near[16] ? 16'(-diff_near) : diff_near[15:0];
  assign elapsed   = in_now_tick - start_tick_r;

  gsc_speed_cmp u_speed (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .scale     (speed_scale_r),
    .fling     (fling_speed_r),
    .dist_last (dist_last),
    .dist_near (dist_near),
    .elapsed   (elapsed),
    .fast      (fast)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      press_r     <= in_pressed;
      pos_r       <= in_position;
      now_r       <= in_now_tick;
      dist_last_r <= dist_last;
      dist_near_r <= dist_near;
      back_r      <= diff_last[16];
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CALC;
      ST_CALC:  if (fast.done) state_nxt = ST_WRITE;
      ST_WRITE: if (!out_valid_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_CALC:  ;
      ST_WRITE: commit = !out_valid_r;
      default:  ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Gesture decision, applied only when the sample commits
  always_comb begin
    is_pressed_nxt = is_pressed_r;
    anchor_nxt     = anchor_r;
    prev_nxt       = prev_r;
    slow_cnt_nxt   = slow_cnt_r;
    start_tick_nxt = start_tick_r;
    ev0            = '{kind: EV_UP, backward: 1'b0, distance: 16'd0, last_of_run: 1'b1};
    ev1            = ev0;
    n_ev           = 2'd0;
    slow_hit       = 1'b0;
    if (!press_r) begin
      if (is_pressed_r) begin
        // release: optional fling or move, then always up
        is_pressed_nxt = 1'b0;
        start_tick_nxt = now_r;
        if (fast.fast_last && (slow_cnt_r < {1'b0, slow_needed_r})) begin
          ev0  = '{kind: EV_FLING, backward: back_r,
                   distance: (dist_last_r == 16'd0) ? 16'd1 : dist_last_r,
                   last_of_run: 1'b0};
          n_ev = 2'd2;
        end else if (dist_last_r >= move_min_r) begin
          ev0  = '{kind: EV_MOVE, backward: back_r, distance: dist_last_r,
                   last_of_run: 1'b0};
          n_ev = 2'd2;
        end else begin
          n_ev = 2'd1;
        end
      end
    end else if (!is_pressed_r) begin
      // press: anchor here and report down
      is_pressed_nxt = 1'b1;
      anchor_nxt     = pos_r;
      prev_nxt       = pos_r;
      slow_cnt_nxt   = 9'd0;
      start_tick_nxt = now_r;
      ev0            = '{kind: EV_DOWN, backward: 1'b0, distance: 16'd0, last_of_run: 1'b1};
      n_ev           = 2'd1;
    end else begin
      prev_nxt = pos_r;
      if (!fast.fast_last || !fast.fast_near) begin
        // slow sample: count, saturating one past the threshold
        if (slow_cnt_r <= {1'b0, slow_needed_r}) slow_cnt_nxt = slow_cnt_r + 9'd1;
        slow_hit = (slow_cnt_nxt >= {1'b0, slow_needed_r});
        if (slow_hit && (dist_last_r >= move_min_r)) begin
          ev0        = '{kind: EV_MOVE, backward: back_r, distance: dist_last_r,
                         last_of_run: 1'b1};
          n_ev       = 2'd1;
          anchor_nxt = pos_r;
        end
      end else begin
        slow_cnt_nxt = 9'd0;
      end
    end
  end

  // Output stage: drain one word per handshake, refill on commit
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (out_valid_r && out_ready) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (commit) begin
      if (n_ev != 2'd0) begin
        out_nxt       = ev0;
        out_valid_nxt = 1'b1;
      end
      if (n_ev == 2'd2) begin
        pend_nxt       = ev1;
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      is_pressed_r <= 1'b0;
      anchor_r     <= '0;
      prev_r       <= '0;
      slow_cnt_r   <= '0;
      start_tick_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (commit) begin
        is_pressed_r <= is_pressed_nxt;
        anchor_r     <= anchor_nxt;
        prev_r       <= prev_nxt;
        slow_cnt_r   <= slow_cnt_nxt;
        start_tick_r <= start_tick_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_r.kind;
  assign out_backward    = out_r.backward;
  assign out_distance    = out_r.distance;
  assign out_last_of_run = out_r.last_of_run;

`ifndef NO_ASSERTIONS
  // The queued word only ever sits behind a full output stage
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("queued word without output word");

  // A word that does not end its run always has its follower queued
  a_run_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last_of_run) |-> pend_valid_r)
    else $error("run cut short in output stage");

  // A release always leaves an up word as the newest entry
  a_release_up: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(is_pressed_r) |->
      ((pend_valid_r && (pend_r.kind == EV_UP)) ||
       (!pend_valid_r && out_valid_r && (out_r.kind == EV_UP))))
    else $error("release without up word");

  // The speed unit reports only while a sample is being worked on
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    fast.done |-> (state_r == ST_CALC))
    else $error("speed result outside calculation");
`endif

endmodule

`default_nettype wire
